// ===== sv/jpeg_eoi_pkg.sv =====
// Package for the JPEG end-of-image locator: widths, codes, phase type and marker helpers.
package jpeg_eoi_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int END_OFFSET_W = 32;
    localparam int STATUS_W = 3;
    localparam int DATA_W = 8;
    localparam int SKIP_W = 16;

    typedef logic [OFFSET_BITS-1:0] t_position;

    localparam t_position POSITION_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_START = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_EARLY     = 3'd4
    } t_status;

    typedef enum logic [9:0] {
        PH_SOI0   = 10'b00_0000_0001,
        PH_SOI1   = 10'b00_0000_0010,
        PH_MARK0  = 10'b00_0000_0100,
        PH_MARK1  = 10'b00_0000_1000,
        PH_LENHI  = 10'b00_0001_0000,
        PH_LENLO  = 10'b00_0010_0000,
        PH_SKIP   = 10'b00_0100_0000,
        PH_SCAN   = 10'b00_1000_0000,
        PH_SCANFF = 10'b01_0000_0000,
        PH_DONE   = 10'b10_0000_0000
    } t_phase;

    localparam logic [DATA_W-1:0] BYTE_FF  = 8'hFF;
    localparam logic [DATA_W-1:0] MK_SOI   = 8'hD8;
    localparam logic [DATA_W-1:0] MK_EOI   = 8'hD9;
    localparam logic [DATA_W-1:0] MK_RST0  = 8'hD0;
    localparam logic [DATA_W-1:0] MK_RST7  = 8'hD7;
    localparam logic [DATA_W-1:0] MK_SOF0  = 8'hC0;
    localparam logic [DATA_W-1:0] MK_SOF2  = 8'hC2;
    localparam logic [DATA_W-1:0] MK_DHT   = 8'hC4;
    localparam logic [DATA_W-1:0] MK_DQT   = 8'hDB;
    localparam logic [DATA_W-1:0] MK_DRI   = 8'hDD;
    localparam logic [DATA_W-1:0] MK_SOS   = 8'hDA;
    localparam logic [DATA_W-1:0] MK_COM   = 8'hFE;
    localparam logic [DATA_W-1:0] MK_APP0  = 8'hE0;
    localparam logic [DATA_W-1:0] MK_APP15 = 8'hEF;

    // Markers followed by a big-endian segment length.
    function automatic logic takes_length(input logic [DATA_W-1:0] m);
        logic r;
        r = (m == MK_SOF0) || (m == MK_SOF2) || (m == MK_DHT) || (m == MK_DQT) ||
            (m == MK_DRI) || (m == MK_COM) || (m == MK_SOS) ||
            ((m >= MK_APP0) && (m <= MK_APP15));
        return r;
    endfunction

    function automatic logic is_restart(input logic [DATA_W-1:0] m);
        return (m >= MK_RST0) && (m <= MK_RST7);
    endfunction

endpackage

// ===== sv/jpeg_end_of_image_locator.sv =====
// Top level: byte-serial JPEG marker walker that reports where the image ends.
// A result is registered: the accepted byte that causes it loads it into the output register.
// Throughput: one byte per cycle while o_in_stall is low; the next parser state is computed combinationally.
// A byte is taken whenever the result register is empty or is being taken in the same cycle.
// Reset (synchronous, active low) returns the parser to "expect FF of SOI", clears the
// byte count and empties the result register; end_of_stream restores parser and count after its byte.
module jpeg_end_of_image_locator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [jpeg_eoi_pkg::DATA_W-1:0]      i_data_byte,
    input  logic                                 i_end_of_stream,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [jpeg_eoi_pkg::STATUS_W-1:0]    o_status,
    output logic [jpeg_eoi_pkg::END_OFFSET_W-1:0] o_end_offset
);

    // Parser state
    jpeg_eoi_pkg::t_phase    r_phase, n_phase;
    jpeg_eoi_pkg::t_position r_pos, n_pos;
    logic [jpeg_eoi_pkg::SKIP_W-1:0] r_skip, n_skip;
    logic [jpeg_eoi_pkg::DATA_W-1:0] r_len_hi, n_len_hi;
    logic                    r_in_scan, n_in_scan;

    // Result register
    logic                    r_out_valid;
    jpeg_eoi_pkg::t_status   r_status;
    logic [jpeg_eoi_pkg::END_OFFSET_W-1:0] r_offset;

    logic                    in_acc;
    logic                    out_acc;
    logic                    emit;
    logic                    was_done;
    jpeg_eoi_pkg::t_status   res_status;
    logic [jpeg_eoi_pkg::END_OFFSET_W-1:0] res_offset;

    // Hold input only while a result sits in the register and the sink stalls it.
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        logic [jpeg_eoi_pkg::SKIP_W-1:0] seg_len;
        logic [jpeg_eoi_pkg::SKIP_W-1:0] skip_dec;
        logic [63:0] pos_wide;
        logic        found;
        logic        next_is_scan;

        n_phase    = r_phase;
        n_skip     = r_skip;
        n_len_hi   = r_len_hi;
        n_in_scan  = r_in_scan;
        emit       = 1'b0;
        found      = 1'b0;
        res_status = jpeg_eoi_pkg::ST_FOUND;

        // Saturating count of bytes consumed, including this one.
        n_pos = (r_pos == jpeg_eoi_pkg::POSITION_MAX) ? r_pos
                : r_pos + jpeg_eoi_pkg::t_position'(1);
        pos_wide = 64'(n_pos);

        seg_len  = {r_len_hi, i_data_byte};
        skip_dec = (r_skip != '0) ? r_skip - 16'd1 : r_skip;
        next_is_scan = r_in_scan;

        // Anything outside the live parse phases counts as finished.
        was_done = !(r_phase == jpeg_eoi_pkg::PH_SOI0  || r_phase == jpeg_eoi_pkg::PH_SOI1  ||
                     r_phase == jpeg_eoi_pkg::PH_MARK0 || r_phase == jpeg_eoi_pkg::PH_MARK1 ||
                     r_phase == jpeg_eoi_pkg::PH_LENHI || r_phase == jpeg_eoi_pkg::PH_LENLO ||
                     r_phase == jpeg_eoi_pkg::PH_SKIP  || r_phase == jpeg_eoi_pkg::PH_SCAN  ||
                     r_phase == jpeg_eoi_pkg::PH_SCANFF);

        case (r_phase)
            jpeg_eoi_pkg::PH_SOI0: begin
                if (i_data_byte == jpeg_eoi_pkg::BYTE_FF) begin
                    n_phase = jpeg_eoi_pkg::PH_SOI1;
                end else begin
                    emit = 1'b1;
                    res_status = jpeg_eoi_pkg::ST_BAD_START;
                end
            end
            jpeg_eoi_pkg::PH_SOI1: begin
                if (i_data_byte == jpeg_eoi_pkg::MK_SOI) begin
                    n_phase = jpeg_eoi_pkg::PH_MARK0;
                end else begin
                    emit = 1'b1;
                    res_status = jpeg_eoi_pkg::ST_BAD_START;
                end
            end
            jpeg_eoi_pkg::PH_MARK0: begin
                if (i_data_byte == jpeg_eoi_pkg::BYTE_FF) begin
                    n_phase = jpeg_eoi_pkg::PH_MARK1;
                end else begin
                    emit = 1'b1;
                    res_status = jpeg_eoi_pkg::ST_UNKNOWN;
                end
            end
            jpeg_eoi_pkg::PH_MARK1: begin
                if (i_data_byte == jpeg_eoi_pkg::MK_EOI) begin
                    emit  = 1'b1;
                    found = 1'b1;
                end else if (jpeg_eoi_pkg::is_restart(i_data_byte)) begin
                    n_phase = jpeg_eoi_pkg::PH_MARK0;
                end else if (jpeg_eoi_pkg::takes_length(i_data_byte)) begin
                    n_in_scan = (i_data_byte == jpeg_eoi_pkg::MK_SOS);
                    n_phase   = jpeg_eoi_pkg::PH_LENHI;
                end else begin
                    emit = 1'b1;
                    res_status = jpeg_eoi_pkg::ST_UNKNOWN;
                end
            end
            jpeg_eoi_pkg::PH_LENHI: begin
                n_len_hi = i_data_byte;
                n_phase  = jpeg_eoi_pkg::PH_LENLO;
            end
            jpeg_eoi_pkg::PH_LENLO: begin
                if (seg_len < 16'd2) begin
                    emit = 1'b1;
                    res_status = jpeg_eoi_pkg::ST_BAD_LEN;
                end else begin
                    n_skip = seg_len - 16'd2;
                    if (seg_len == 16'd2) begin
                        n_phase = next_is_scan ? jpeg_eoi_pkg::PH_SCAN
                                               : jpeg_eoi_pkg::PH_MARK0;
                    end else begin
                        n_phase = jpeg_eoi_pkg::PH_SKIP;
                    end
                end
            end
            jpeg_eoi_pkg::PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    n_phase = next_is_scan ? jpeg_eoi_pkg::PH_SCAN
                                           : jpeg_eoi_pkg::PH_MARK0;
                end
            end
            jpeg_eoi_pkg::PH_SCAN: begin
                if (i_data_byte == jpeg_eoi_pkg::BYTE_FF) begin
                    n_phase = jpeg_eoi_pkg::PH_SCANFF;
                end
            end
            jpeg_eoi_pkg::PH_SCANFF: begin
                // Fill bytes keep us here; EOI ends the image; other bytes resume scan.
                if (i_data_byte == jpeg_eoi_pkg::MK_EOI) begin
                    emit  = 1'b1;
                    found = 1'b1;
                end else if (i_data_byte != jpeg_eoi_pkg::BYTE_FF) begin
                    n_phase = jpeg_eoi_pkg::PH_SCAN;
                end
            end
            default: begin
            end
        endcase

        res_offset = found ? pos_wide[jpeg_eoi_pkg::END_OFFSET_W-1:0] : '0;

        if (emit) begin
            n_phase = jpeg_eoi_pkg::PH_DONE;
        end

        // Last byte of the file: report an early end if nothing else was said, then restart.
        if (i_end_of_stream) begin
            if (!emit && !was_done) begin
                emit       = 1'b1;
                res_status = jpeg_eoi_pkg::ST_EARLY;
                res_offset = '0;
            end
            n_phase   = jpeg_eoi_pkg::PH_SOI0;
            n_pos     = '0;
            n_skip    = '0;
            n_len_hi  = '0;
            n_in_scan = 1'b0;
        end
    end

    // Parser state: advance on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jpeg_eoi_pkg::PH_SOI0;
            r_pos     <= '0;
            r_skip    <= '0;
            r_len_hi  <= '0;
            r_in_scan <= 1'b0;
        end else if (in_acc) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_len_hi  <= n_len_hi;
            r_in_scan <= n_in_scan;
        end
    end

    // Result register: load on an item that reports, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= emit;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_status <= res_status;
            r_offset <= res_offset;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_end_offset = r_offset;

    // Only a found end carries an offset.
    a_offset_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != jpeg_eoi_pkg::ST_FOUND) |-> (r_offset == '0))
        else $error("nonzero end offset on an error result");

    // End of stream restarts the parser from the start marker with a clear count.
    a_eos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_stream) |=> (r_phase == jpeg_eoi_pkg::PH_SOI0 && r_pos == '0))
        else $error("parser not restarted after end of stream");

    // A file that has not yet reported always reports on its last byte.
    a_eos_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_stream && !was_done) |=> r_out_valid)
        else $error("no result for a file that ended");

    // The skip phase is only held with bytes left to skip.
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == jpeg_eoi_pkg::PH_SKIP) |-> (r_skip != '0))
        else $error("skip phase with nothing left to skip");

endmodule
